/* src/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int OP_W             = 3;
    localparam int STATUS_W         = 2;
    localparam int IN_TDATA_W       = 40;
    localparam int OUT_TDATA_W      = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DISPLAY    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic                     last;
    } t_result;

endpackage

/* src/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring memory.
// ----------------------------------------------------------------------------
// Each input item holds an operation and a value. A push that finds room is
// written to the slot memory in the cycle it is accepted and its result is
// registered in the output register, so pushes run one item per cycle while
// the output is not stalled. A pop reads the registered memory read port and
// hands on its data from the read state. A display reads the stored elements
// front to back through the single memory read port; an empty queue gives
// one result. The next item is taken once the current one has handed its final
// result to the output register, and unused operation codes give no result.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] op, [34:3] value, [39:35] zero
    input  logic [deq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] data, [33:32] status, [39:34] zero
    output logic [deq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    import deq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic              out_free;
    logic              res_valid;
    t_result           res;
    logic              busy;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    logic              r_out_valid;
    t_result           r_out;

    assign out_free = !r_out_valid || m_axis_tready;

    deq_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tdata[OP_W-1:0]),
        .i_value     (s_axis_tdata[OP_W+DATA_W-1:OP_W]),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_busy      (busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    deq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - STATUS_W){1'b0}},
                            r_out.status, r_out.data};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result produced while the output register is stalled");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res.last) |=> busy)
        else $error("display run ended before its final element");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status != ST_OK) |-> (res.data == '0 && res.last))
        else $error("empty or full report carries data or is not final");

endmodule

/* src/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram
// Slot memory of the queue: one write port and one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// Front pointer, fill count and sequencer of the queue operations.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [deq_pkg::OP_W-1:0]          i_op,
    input  logic [deq_pkg::DATA_W-1:0]        i_value,
    input  logic                              i_out_free,
    output logic                              o_res_valid,
    output deq_pkg::t_result                  o_res,
    output logic                              o_busy,
    output logic                              o_we,
    output logic [IW-1:0]                     o_waddr,
    output logic [deq_pkg::DATA_W-1:0]        o_wdata,
    output logic                              o_re,
    output logic [IW-1:0]                     o_raddr,
    input  logic [deq_pkg::DATA_W-1:0]        i_rdata
);

    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DISP = 3'b100
    } t_state;

    localparam logic [CW:0]   CAP_S    = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    function automatic logic [IW-1:0] f_wrap(input logic [CW:0] s);
        logic [CW:0] r;
        r = (s >= CAP_S) ? s - CAP_S : s;
        return r[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IW'(1);
    endfunction

    t_state        r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_occ,   n_occ;
    logic [IW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_cnt,   n_cnt;

    logic          accept;
    logic          empty;
    logic          full;
    logic [CW:0]   back_sum;
    logic          disp_last;

    assign o_ready   = (r_state == S_IDLE) && i_out_free;
    assign accept    = i_valid && o_ready;
    assign empty     = (r_occ == '0);
    assign full      = (r_occ == CAP_C);
    assign back_sum  = (CW+1)'(r_front) + (CW+1)'(r_occ);
    assign disp_last = ((r_cnt + ONE_C) == r_occ);
    assign o_busy    = (r_state != S_IDLE);
    assign o_wdata   = i_value;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        o_we        = 1'b0;
        o_waddr     = f_wrap(back_sum);
        o_re        = 1'b0;
        o_raddr     = r_front;
        o_res_valid = 1'b0;
        o_res       = '{data: '0, status: ST_OK, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            o_res_valid = 1'b1;
                            if (full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_we  = 1'b1;
                                n_occ = r_occ + ONE_C;
                                if (i_op == OP_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? LAST_IDX
                                                              : r_front - IW'(1);
                                    o_waddr = n_front;
                                end
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT: begin
                            if (empty) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                o_re    = 1'b1;
                                n_occ   = r_occ - ONE_C;
                                n_state = S_READ;
                                if (i_op == OP_POP_FRONT) begin
                                    n_front = f_next(r_front);
                                end else begin
                                    o_raddr = f_wrap(back_sum - (CW+1)'(1));
                                end
                            end
                        end
                        OP_DISPLAY: begin
                            if (empty) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                o_re    = 1'b1;
                                n_idx   = f_next(r_front);
                                n_cnt   = '0;
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    o_res.data  = i_rdata;
                    n_state     = S_IDLE;
                end
            end
            S_DISP: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    o_res.data  = i_rdata;
                    o_res.last  = disp_last;
                    if (disp_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_idx;
                        n_idx   = f_next(r_idx);
                        n_cnt   = r_cnt + ONE_C;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking stream testbench for the double-ended queue.
// ----------------------------------------------------------------------------
// A backlog of operations is driven into the queue with random gaps while the
// output side applies random back-pressure and one long hold-off. A behavioral
// ring model predicts every result at input acceptance, and each output item
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import deq_pkg::*;

    localparam int CAP        = DEFAULT_CAPACITY;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_ITEMS    = 360;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
    } t_cmd;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // [2:0] op, [34:3] value, [39:35] zero
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [31:0] data, [33:32] status, [39:34] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    logic [DATA_W-1:0] ring_mem [CAP];
    int unsigned       head_idx;
    int unsigned       fill;

    t_result exp_results [$];
    t_cmd    cmd_backlog [$];

    int          errors;
    int          results_seen;
    int          idle_cycles;
    int unsigned cycle_no;
    int          tx_gap;
    int          rx_gap;
    int          rx_hold;
    bit          hold_done;
    bit          in_accepted;

    double_ended_queue #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 20) begin
            $display("MISMATCH at cycle %0d: %s", cycle_no, msg);
        end
    endtask

    task automatic queue_result(input logic [DATA_W-1:0] d, input t_status st,
                                input logic lst);
        t_result r;
        r.data   = d;
        r.status = st;
        r.last   = lst;
        exp_results.push_back(r);
    endtask

    // Updates the ring model with one accepted item and queues its results.
    task automatic deque_apply(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int unsigned idx;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (fill >= CAP) begin
                    queue_result('0, ST_FULL, 1'b1);
                end else begin
                    if (op == OP_PUSH_BACK) begin
                        ring_mem[(head_idx + fill) % CAP] = val;
                    end else begin
                        head_idx = (head_idx + CAP - 1) % CAP;
                        ring_mem[head_idx] = val;
                    end
                    fill++;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (fill == 0) begin
                    queue_result('0, ST_EMPTY, 1'b1);
                end else begin
                    if (op == OP_POP_BACK) begin
                        idx = (head_idx + fill - 1) % CAP;
                    end else begin
                        idx = head_idx;
                        head_idx = (head_idx + 1) % CAP;
                    end
                    fill--;
                    queue_result(ring_mem[idx], ST_OK, 1'b1);
                end
            end
            OP_DISPLAY: begin
                if (fill == 0) begin
                    queue_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < fill; i++) begin
                        queue_result(ring_mem[(head_idx + i) % CAP], ST_OK, i + 1 == fill);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        t_cmd c;
        c.op  = op;
        c.val = val;
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_drained(input int settle);
        while (cmd_backlog.size() != 0 || s_axis_tvalid || exp_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        cycle_no++;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            deque_apply(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W+DATA_W-1:OP_W]);
            in_accepted = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (exp_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%h status=%0d last=%0b",
                    m_axis_tdata[DATA_W-1:0], m_axis_tdata[DATA_W+STATUS_W-1:DATA_W],
                    m_axis_tlast));
            end else begin
                want = exp_results.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== want.data) begin
                    report_mismatch($sformatf("data %h, expected %h",
                        m_axis_tdata[DATA_W-1:0], want.data));
                end
                if (m_axis_tdata[DATA_W+STATUS_W-1:DATA_W] !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_axis_tdata[DATA_W+STATUS_W-1:DATA_W], want.status));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                        m_axis_tlast, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        t_cmd cmd;
        if (!s_axis_tvalid || in_accepted) begin
            in_accepted = 1'b0;
            if (tx_gap > 0 || cmd_backlog.size() == 0) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end
                s_axis_tvalid <= 1'b0;
            end else begin
                cmd = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_TDATA_W - DATA_W - OP_W){1'b0}}, cmd.val, cmd.op};
                tx_gap = pick_gap(cycle_no[7]);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 120) begin
            hold_done = 1'b1;
            rx_hold   = 300;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = pick_gap(cycle_no[8]);
        end
    end

    initial begin
        int n_real;
        int push_pct;
        int r;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        head_idx      = 0;
        fill          = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_DISPLAY, 32'h0);
        send(OP_POP_BACK, 32'h0);
        send(OP_POP_FRONT, 32'h0);
        send(3'd5, 32'hFFFF_FFFF);
        send(3'd7, 32'hFFFF_FFFF);
        send(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send(OP_PUSH_FRONT, 32'h8000_0000);
        send(OP_DISPLAY, 32'hFFFF_FFFF);
        send(OP_POP_BACK, 32'h0);
        send(OP_POP_FRONT, 32'h0);
        for (int i = 0; i < CAP; i++) begin
            send(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, i[1] ? 32'hFFFF_FFFF - i : i);
        end
        send(OP_PUSH_BACK, 32'h1234_5678);
        send(OP_PUSH_FRONT, 32'h8765_4321);
        send(OP_DISPLAY, 32'h0);
        wait_drained(20);

        n_real   = 0;
        push_pct = 50;
        while (n_real < N_ITEMS - 28) begin
            if (n_real % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 50;
                    default: push_pct = 10;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send(OP_W'($urandom_range(5, 7)), $urandom);
            end else begin
                n_real++;
                if (r < 11) begin
                    send(OP_DISPLAY, $urandom);
                end else if ($urandom_range(0, 99) < push_pct) begin
                    send($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
                end else begin
                    send($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
                end
                if (n_real == 160) begin
                    wait_drained(20);
                end
            end
        end

        wait_drained(40);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* double_ended_queue.f */
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
test/tb.sv
